[hw/rtl/lesq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_pkg
// Shared types, constants and helpers for the LED effect sequencer with
// the two-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
package lesq_pkg;

    // Number of off/on pairs in the blink effect (1..22)
    localparam int BLINK_PAIRS = 8;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int SEL_W   = 3;
    localparam int POS_W   = 6;
    localparam int DIGIT_W = 4;
    localparam int SLOT_W  = 2;

    // Stream packing: tdata of the result is 27 bits of fields padded to 32
    localparam int OUT_DATA_W = 32;

    // Event codes carried in the request's tuser
    localparam logic [FUNC_W-1:0] FUNC_STEP = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCAN = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UP   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DOWN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CMD  = 3'd4;

    // Display scan slots
    localparam logic [SLOT_W-1:0] SLOT_LEFT  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_BLANK = 2'd2;

    // Digit select codes
    localparam logic [SEL_W-1:0] SEL_LEFT  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_RIGHT = 3'd4;

    // Modes
    localparam logic [BYTE_W-1:0] MODE_CHAIN  = 8'd0;
    localparam logic [BYTE_W-1:0] MODE_FILL   = 8'd1;
    localparam logic [BYTE_W-1:0] MODE_UNFILL = 8'd2;
    localparam logic [BYTE_W-1:0] MODE_BLINK  = 8'd3;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'd48;

    // Effect lengths in steps
    localparam logic [POS_W-1:0] FILL_LEN  = 6'd9;
    localparam logic [POS_W-1:0] BLINK_LEN = POS_W'(2 * BLINK_PAIRS);
    localparam logic [POS_W-1:0] CHAIN_LEN = POS_W'(18 + 2 * BLINK_PAIRS);

    // Fill and unfill boundaries inside the chained effect
    localparam logic [POS_W-1:0] UNFILL_START = 6'd9;
    localparam logic [POS_W-1:0] BLINK_START  = 6'd18;
    localparam logic [DIGIT_W-1:0] LAST_FILL  = 4'd8;

    localparam logic [7:0] LEDS_ALL_ON = 8'hFF;
    localparam logic [7:0] LEDS_OFF    = 8'h00;

    // Output of the effect lookup
    typedef struct packed {
        logic [7:0]         leds;
        logic [DIGIT_W-1:0] left_digit;
    } effect_t;

    // One result item
    typedef struct packed {
        logic [7:0]       leds;
        logic [SEL_W-1:0] seg_select;
        logic [7:0]       seg_code;
        logic [7:0]       mode;
        logic             cmd_ack;
    } result_t;

    // 0xFF shifted left by k; all off once k reaches 8
    function automatic logic [7:0] fill_pattern(input logic [DIGIT_W-1:0] k);
        logic [15:0] wide;
        begin
            wide = 16'h00FF << k;
            fill_pattern = wide[7:0];
        end
    endfunction

    // Seven-segment font, blank above 9
    function automatic logic [7:0] seg_font(input logic [DIGIT_W-1:0] d);
        logic [7:0] code;
        begin
            unique case (d)
                4'd0:    code = 8'h3F;
                4'd1:    code = 8'h06;
                4'd2:    code = 8'h5B;
                4'd3:    code = 8'h4F;
                4'd4:    code = 8'h66;
                4'd5:    code = 8'h6D;
                4'd6:    code = 8'h7D;
                4'd7:    code = 8'h07;
                4'd8:    code = 8'h7F;
                4'd9:    code = 8'h6F;
                default: code = 8'h00;
            endcase
            seg_font = code;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/led_effect_sequencer_with_seg_mux_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_effect_sequencer_with_seg_mux_core
// LED effect sequencer with mode control and a two-digit multiplexed
// seven-segment display, behind stream ports.
//
// Channel  Dir  Signals                  Contents (low bit first)
// s_axis   in   tvalid tready tdata      tdata[7:0] rx_byte
//                      tuser             tuser[2:0] func
// m_axis   out  tvalid tready tdata      leds[7:0] seg_select[10:8]
//                                        seg_code[18:11] mode[26:19] 0[31:27]
//                      tuser             tuser[0] cmd_ack
//
// One request per cycle sustained while m_axis accepts. An accepted request sits
// in the input register while the combinational event logic runs, and the
// result register loads the result once it is free; m_axis then offers it.
// Reset (rst_n low) returns mode 0, step 0, LEDs all on and a dark display.
// A stall on m_axis holds the result; s_axis stalls only while the input
// register is full and the result register cannot free in the same cycle.
// ----------------------------------------------------------------------------
module led_effect_sequencer_with_seg_mux_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,  // rx_byte
    input  wire logic [lesq_pkg::FUNC_W-1:0]      s_axis_tuser,  // func
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output      logic [lesq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // leds, seg_select,
                                                                 // seg_code, mode
    output      logic                             m_axis_tuser   // cmd_ack
);
    import lesq_pkg::*;

    logic              in_valid_reg,  in_valid_next;
    logic [FUNC_W-1:0] func_reg;
    logic [BYTE_W-1:0] rx_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           result;
    logic              out_free;
    logic              advance;
    logic              accept;

    // Handshake: the event stage moves whenever the result register frees
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= s_axis_tuser;
            rx_byte_reg <= s_axis_tdata;
        end
    end

    // Event logic and sequencer state
    lesq_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (advance),
        .func     (func_reg),
        .rx_byte  (rx_byte_reg),
        .result   (result)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.mode, out_reg.seg_code,
                            out_reg.seg_select, out_reg.leds};
    assign m_axis_tuser  = out_reg.cmd_ack;

endmodule

`default_nettype wire

[hw/rtl/lesq_effect.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_effect
// Maps a valid mode and a step position to the LED pattern and the left
// digit of that step (fill, unfill, blink, or the chain of all three).
// ----------------------------------------------------------------------------
module lesq_effect
(
    input  wire logic [1:0]                 mode_lo,
    input  wire logic [lesq_pkg::POS_W-1:0] pos,
    output lesq_pkg::effect_t               effect
);
    import lesq_pkg::*;

    logic               is_fill;
    logic               is_unfill;
    logic [POS_W-1:0]   k_wide;
    logic [DIGIT_W-1:0] k;
    logic [DIGIT_W-1:0] unfill_k;

    // Pick the effect kind and the step within it
    always_comb
    begin
        is_fill   = 1'b0;
        is_unfill = 1'b0;
        k_wide    = pos;
        unique case (mode_lo)
            MODE_CHAIN[1:0]:
            begin
                if (pos < UNFILL_START)
                begin
                    is_fill = 1'b1;
                end
                else if (pos < BLINK_START)
                begin
                    is_unfill = 1'b1;
                    k_wide    = pos - UNFILL_START;
                end
            end
            MODE_FILL[1:0]:   is_fill   = 1'b1;
            MODE_UNFILL[1:0]: is_unfill = 1'b1;
            default:          ;
        endcase
    end

    assign k        = k_wide[DIGIT_W-1:0];
    assign unfill_k = LAST_FILL - k;

    // Pattern and digit; blink parity equals position parity in every mode
    always_comb
    begin
        if (is_fill)
        begin
            effect.leds       = fill_pattern(k);
            effect.left_digit = k;
        end
        else if (is_unfill)
        begin
            effect.leds       = fill_pattern(unfill_k);
            effect.left_digit = unfill_k;
        end
        else if (!pos[0])
        begin
            effect.leds       = LEDS_OFF;
            effect.left_digit = '0;
        end
        else
        begin
            effect.leds       = LEDS_ALL_ON;
            effect.left_digit = LAST_FILL;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lesq_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_engine
// Sequencer state: mode, step position, digits, scan slot and the driven
// outputs. Applies one event per cycle and presents the resulting item.
// ----------------------------------------------------------------------------
module lesq_engine
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        ev_valid,
    input  wire logic [lesq_pkg::FUNC_W-1:0] func,
    input  wire logic [lesq_pkg::BYTE_W-1:0] rx_byte,
    output lesq_pkg::result_t                result
);
    import lesq_pkg::*;

    logic [7:0]         mode_reg,        mode_next;
    logic [POS_W-1:0]   step_pos_reg,    step_pos_next;
    logic [DIGIT_W-1:0] left_digit_reg,  left_digit_next;
    logic [1:0]         right_digit_reg, right_digit_next;
    logic [SLOT_W-1:0]  scan_slot_reg,   scan_slot_next;
    logic [7:0]         led_out_reg,     led_out_next;
    logic [SEL_W-1:0]   select_out_reg,  select_out_next;
    logic [7:0]         segment_out_reg, segment_out_next;

    logic               mode_valid;
    logic [POS_W-1:0]   effect_len;
    logic [POS_W-1:0]   step_inc;
    logic [POS_W-1:0]   step_wrapped;
    logic [7:0]         new_mode;
    logic               mode_event;
    logic               mode_change;
    logic [1:0]         eff_mode;
    logic [POS_W-1:0]   eff_pos;
    effect_t            effect;

    assign mode_valid = (mode_reg <= MODE_BLINK);

    // Length of the running effect and the wrapped next step
    always_comb
    begin
        if (mode_reg == MODE_CHAIN)
        begin
            effect_len = CHAIN_LEN;
        end
        else if (mode_reg == MODE_BLINK)
        begin
            effect_len = BLINK_LEN;
        end
        else
        begin
            effect_len = FILL_LEN;
        end
    end

    assign step_inc     = step_pos_reg + POS_W'(1);
    assign step_wrapped = (step_inc >= effect_len) ? '0 : step_inc;

    // Requested mode for up, down and command events
    always_comb
    begin
        mode_event = 1'b1;
        new_mode   = mode_reg;
        unique case (func)
            FUNC_UP:   new_mode = (mode_reg >= MODE_BLINK) ? MODE_CHAIN
                                                           : mode_reg + 8'd1;
            FUNC_DOWN: new_mode = {6'd0, mode_reg[1:0] + 2'd3};
            FUNC_CMD:  new_mode = rx_byte - ASCII_ZERO;
            default:   mode_event = 1'b0;
        endcase
    end

    assign mode_change = ev_valid && mode_event && (new_mode != mode_reg);

    // Shared effect lookup: new mode at step 0, or current mode at next step
    assign eff_mode = mode_change ? new_mode[1:0] : mode_reg[1:0];
    assign eff_pos  = mode_change ? '0 : step_wrapped;

    lesq_effect u_effect
    (
        .mode_lo (eff_mode),
        .pos     (eff_pos),
        .effect  (effect)
    );

    // Next-state logic
    always_comb
    begin
        mode_next        = mode_reg;
        step_pos_next    = step_pos_reg;
        left_digit_next  = left_digit_reg;
        right_digit_next = right_digit_reg;
        scan_slot_next   = scan_slot_reg;
        led_out_next     = led_out_reg;
        select_out_next  = select_out_reg;
        segment_out_next = segment_out_reg;

        if (ev_valid && func == FUNC_STEP && mode_valid)
        begin
            step_pos_next    = step_wrapped;
            led_out_next     = effect.leds;
            left_digit_next  = effect.left_digit;
            right_digit_next = mode_reg[1:0];
        end

        if (ev_valid && func == FUNC_SCAN)
        begin
            unique case (scan_slot_reg)
                SLOT_LEFT:
                begin
                    select_out_next  = SEL_LEFT;
                    segment_out_next = seg_font(left_digit_reg);
                    scan_slot_next   = SLOT_RIGHT;
                end
                SLOT_RIGHT:
                begin
                    select_out_next  = SEL_RIGHT;
                    segment_out_next = seg_font({2'd0, right_digit_reg});
                    scan_slot_next   = SLOT_BLANK;
                end
                default:
                begin
                    segment_out_next = '0;
                    scan_slot_next   = SLOT_LEFT;
                end
            endcase
        end

        if (mode_change)
        begin
            mode_next     = new_mode;
            step_pos_next = '0;
            if (new_mode <= MODE_BLINK)
            begin
                led_out_next     = effect.leds;
                left_digit_next  = effect.left_digit;
                right_digit_next = new_mode[1:0];
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_CHAIN;
            step_pos_reg    <= '0;
            left_digit_reg  <= '0;
            right_digit_reg <= '0;
            scan_slot_reg   <= SLOT_LEFT;
            led_out_reg     <= LEDS_ALL_ON;
            select_out_reg  <= SEL_LEFT;
            segment_out_reg <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            step_pos_reg    <= step_pos_next;
            left_digit_reg  <= left_digit_next;
            right_digit_reg <= right_digit_next;
            scan_slot_reg   <= scan_slot_next;
            led_out_reg     <= led_out_next;
            select_out_reg  <= select_out_next;
            segment_out_reg <= segment_out_next;
        end
    end

    // Item produced by this event: state after it
    assign result.leds       = led_out_next;
    assign result.seg_select = select_out_next;
    assign result.seg_code   = segment_out_next;
    assign result.mode       = mode_next;
    assign result.cmd_ack    = (func == FUNC_CMD);

endmodule

`default_nettype wire

[bench/led_effect_sequencer_with_seg_mux_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_effect_sequencer_with_seg_mux_core_tb
// Self-checking bench for the LED effect sequencer with the multiplexed
// seven-segment display. Events go in on s_axis. A local model of the
// sequencer predicts every result, and each m_axis result is compared field
// by field with the oldest prediction. The run covers a directed pass, a
// back-pressure pass and random event runs under three idle profiles.
// ----------------------------------------------------------------------------
module led_effect_sequencer_with_seg_mux_core_tb;
    import lesq_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 360;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    localparam logic [7:0] DIGIT_FONT [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // rx_byte
    logic [FUNC_W-1:0]      s_axis_tuser;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // leds, seg_select, seg_code, mode, pad
    logic                   m_axis_tuser;   // cmd_ack

    // Model state of the sequencer
    logic [BYTE_W-1:0]      seq_mode;
    logic [POS_W-1:0]       seq_pos;
    logic [DIGIT_W-1:0]     seq_left;
    logic [1:0]             seq_right;
    logic [SLOT_W-1:0]      seq_slot;
    logic [7:0]             seq_leds;
    logic [SEL_W-1:0]       seq_sel;
    logic [7:0]             seq_seg;

    result_t                pending_results[$];
    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    int                     hold_left   = 0;

    led_effect_sequencer_with_seg_mux_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Steps in the effect that the mode loops over
    function automatic int effect_steps(input logic [BYTE_W-1:0] m);
        if (m == MODE_CHAIN)
            return 18 + 2 * BLINK_PAIRS;
        if (m == MODE_BLINK)
            return 2 * BLINK_PAIRS;
        return 9;
    endfunction

    // Show the current step of the running effect
    function automatic void show_effect_step();
        int kind;
        int k;
        kind = 0;
        k    = seq_pos;
        if (seq_mode == MODE_CHAIN)
        begin
            if (seq_pos < 9)
                kind = 0;
            else if (seq_pos < 18)
            begin
                kind = 1;
                k    = seq_pos - 9;
            end
            else
            begin
                kind = 2;
                k    = seq_pos - 18;
            end
        end
        else
            kind = seq_mode - 1;
        if (kind == 0)
        begin
            seq_leds = 8'hFF << k;
            seq_left = DIGIT_W'(k);
        end
        else if (kind == 1)
        begin
            seq_leds = 8'hFF << (8 - k);
            seq_left = DIGIT_W'(8 - k);
        end
        else if (k % 2 == 0)
        begin
            seq_leds = 8'h00;
            seq_left = 4'd0;
        end
        else
        begin
            seq_leds = 8'hFF;
            seq_left = 4'd8;
        end
        seq_right = seq_mode[1:0];
    endfunction

    // A new mode restarts its effect; an unchanged mode does nothing
    function automatic void switch_mode(input logic [BYTE_W-1:0] nm);
        if (nm == seq_mode)
            return;
        seq_mode = nm;
        seq_pos  = '0;
        if (seq_mode <= MODE_BLINK)
            show_effect_step();
    endfunction

    // Apply one event to the model and return the display it leaves
    function automatic result_t predict_display(input logic [FUNC_W-1:0] f,
                                                input logic [7:0] b);
        result_t r;
        int      n;
        case (f)
            FUNC_STEP:
            begin
                if (seq_mode <= MODE_BLINK)
                begin
                    n = seq_pos + 1;
                    if (n >= effect_steps(seq_mode))
                        n = 0;
                    seq_pos = POS_W'(n);
                    show_effect_step();
                end
            end
            FUNC_SCAN:
            begin
                if (seq_slot == SLOT_LEFT)
                begin
                    seq_sel  = SEL_LEFT;
                    seq_seg  = (seq_left <= 9) ? DIGIT_FONT[seq_left] : 8'h00;
                    seq_slot = SLOT_RIGHT;
                end
                else if (seq_slot == SLOT_RIGHT)
                begin
                    seq_sel  = SEL_RIGHT;
                    seq_seg  = DIGIT_FONT[seq_right];
                    seq_slot = SLOT_BLANK;
                end
                else
                begin
                    seq_seg  = 8'h00;
                    seq_slot = SLOT_LEFT;
                end
            end
            FUNC_UP:   switch_mode((seq_mode >= MODE_BLINK) ? MODE_CHAIN : seq_mode + 8'd1);
            FUNC_DOWN: switch_mode({6'd0, seq_mode[1:0] + 2'd3});
            FUNC_CMD:  switch_mode(b - ASCII_ZERO);
            default:   ;
        endcase
        r.leds       = seq_leds;
        r.seg_select = seq_sel;
        r.seg_code   = seq_seg;
        r.mode       = seq_mode;
        r.cmd_ack    = (f == FUNC_CMD);
        return r;
    endfunction

    // Send one request; returns at the falling edge after acceptance
    task automatic send_event(input logic [FUNC_W-1:0] f, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = f;
        s_axis_tdata  = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_display(f, b));
        @(negedge clk);
    endtask

    // Random-content events, mostly as runs after a mode change
    task automatic send_any();
        send_event($urandom_range(1) ? FUNC_STEP : FUNC_SCAN, 8'($urandom));
    endtask

    // Receiver: random stalls plus an optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %h/%b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("leds", exp_r.leds, m_axis_tdata[7:0]);
                check_field("seg_select", 8'(exp_r.seg_select), 8'(m_axis_tdata[10:8]));
                check_field("seg_code", exp_r.seg_code, m_axis_tdata[18:11]);
                check_field("mode", exp_r.mode, m_axis_tdata[26:19]);
                check_field("pad", 8'd0, 8'(m_axis_tdata[31:27]));
                check_field("cmd_ack", 8'(exp_r.cmd_ack), 8'(m_axis_tuser));
            end
        end
    end

    // Every event kind, the byte extremes, invalid modes and repeated commands
    task automatic test_directed();
        tx_idle_pct = 13;
        rx_idle_pct = 68;
        send_event(FUNC_SCAN, 8'h00);
        send_event(FUNC_SCAN, 8'hFF);
        send_event(FUNC_SCAN, 8'h00);
        send_event(FUNC_STEP, 8'hFF);
        send_event(FUNC_STEP, 8'h00);
        send_event(FUNC_SPARE_5, 8'hFF);
        send_event(FUNC_SPARE_6, 8'h00);
        send_event(FUNC_SPARE_7, 8'hAA);
        send_event(FUNC_UP, 8'h55);
        send_event(FUNC_DOWN, 8'h00);
        send_event(FUNC_DOWN, 8'h00);
        send_event(FUNC_STEP, 8'h00);
        send_event(FUNC_UP, 8'h00);
        send_event(FUNC_CMD, ASCII_ZERO + 8'd2);
        send_event(FUNC_STEP, 8'h00);
        // same mode again: acknowledged, effect keeps its step
        send_event(FUNC_CMD, ASCII_ZERO + 8'd2);
        send_event(FUNC_CMD, 8'h00);
        // invalid mode: step ignored, digits frozen
        send_event(FUNC_STEP, 8'h00);
        send_event(FUNC_SCAN, 8'h00);
        send_event(FUNC_SCAN, 8'h00);
        send_event(FUNC_UP, 8'h00);
        send_event(FUNC_CMD, 8'hFF);
        send_event(FUNC_DOWN, 8'h00);
        send_event(FUNC_CMD, ASCII_ZERO + 8'd3);
        send_event(FUNC_CMD, ASCII_ZERO);
    endtask

    // Receiver holds off while requests keep coming, filling the pipeline
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = 150;
        repeat (40)
            send_any();
    endtask

    // Mode changes followed by runs of steps and scans, plus noise
    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int sent;
        int sel;
        int run_len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent        = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
            begin
                run_len = $urandom_range(1, 4);
                repeat (run_len)
                    send_event(FUNC_W'($urandom_range(7)), 8'($urandom));
            end
            else
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                    send_event(FUNC_CMD, ASCII_ZERO + 8'($urandom_range(3)));
                else if (sel < 85)
                    send_event(FUNC_UP, 8'($urandom));
                else
                    send_event(FUNC_DOWN, 8'($urandom));
                run_len = $urandom_range(10, 70);
                repeat (run_len)
                    send_any();
                run_len++;
            end
            sent += run_len;
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_STEP;
        seq_mode      = MODE_CHAIN;
        seq_pos       = '0;
        seq_left      = '0;
        seq_right     = '0;
        seq_slot      = SLOT_LEFT;
        seq_leds      = LEDS_ALL_ON;
        seq_sel       = SEL_LEFT;
        seq_seg       = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_traffic(13, 68);
        test_random_traffic(68, 13);
        test_random_traffic(0, 0);
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
